/* rtl/core/lfupt_pkg.sv */
package lfupt_pkg;

   localparam int PROC_W  = 8;
   localparam int PAGE_W  = 20;
   localparam int SLOT_W  = 3;
   localparam int MATCH_W = 4;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_ACCESS = 1'b1;

   localparam int INIT_COUNT = 1;

   typedef logic [PROC_W-1:0] proc_type;
   typedef logic [PAGE_W-1:0] page_type;

endpackage

/* rtl/core/lfupt_ram.sv */
module lfupt_ram #(
   parameter int WIDTH = 44,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/lfu_page_table_unit.sv */
// LFU page table.
// Input channel req_*: one transfer carries a command (insert or access), a
// process id and a page number. Result channel rsp_*: exactly one transfer per
// request, in request order, with the slot written by an insert, the eviction
// flag, the evicted entry's fields and the number of entries that an access
// matched by process id.
// An insert while the table still has free slots writes straight away. An
// insert into a full table scans for the lowest count, one entry per cycle
// through the single table memory, then writes. An access does the same scan,
// writing counts back as it goes.
// One request is worked on at a time; req_ready is high only while idle.
// The finished result sits in an output register, so a new request can be
// taken while the previous result is still waiting; when rsp_ready is held
// low the block finishes its work and then holds in its last step until the
// output register frees.
// Reset empties the table (fill count to zero) and drops any pending result;
// no clearing pass is needed as slots fill in order.
module lfu_page_table_unit #(
   parameter int ENTRIES     = 8,
   parameter int COUNT_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_cmd,
   input  logic [lfupt_pkg::PROC_W-1:0]  req_proc_id,
   input  logic [lfupt_pkg::PAGE_W-1:0]  req_page_num,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [lfupt_pkg::SLOT_W-1:0]  rsp_slot,
   output logic                          rsp_evicted,
   output logic [lfupt_pkg::PROC_W-1:0]  rsp_victim_proc,
   output logic [lfupt_pkg::PAGE_W-1:0]  rsp_victim_page,
   output logic [lfupt_pkg::MATCH_W-1:0] rsp_match_count
);

   localparam int IW   = $clog2(ENTRIES);
   localparam int CNTW = $clog2(ENTRIES + 1);
   localparam int DW   = lfupt_pkg::PROC_W + lfupt_pkg::PAGE_W + COUNT_WIDTH;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_WRITE = 2'd2;
   localparam logic [1:0] S_RESP  = 2'd3;

   localparam logic [COUNT_WIDTH-1:0] CNT_INIT = COUNT_WIDTH'(lfupt_pkg::INIT_COUNT);
   localparam logic [COUNT_WIDTH-1:0] CNT_MAX  = {COUNT_WIDTH{1'b1}};
   localparam logic [CNTW-1:0]        FULL     = CNTW'(ENTRIES);

   logic [1:0]               state_ff, state_in;
   logic [CNTW-1:0]          fill_ff, fill_in;
   logic [CNTW-1:0]          scan_ff, scan_in;
   logic [CNTW-1:0]          matches_ff, matches_in;
   logic                     cmd_ff, cmd_in;
   lfupt_pkg::proc_type      pid_ff, pid_in;
   lfupt_pkg::page_type      page_ff, page_in;
   logic [IW-1:0]            slot_ff, slot_in;
   logic                     evict_ff, evict_in;
   logic [COUNT_WIDTH-1:0]   best_cnt_ff, best_cnt_in;
   lfupt_pkg::proc_type      vproc_ff, vproc_in;
   lfupt_pkg::page_type      vpage_ff, vpage_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [IW-1:0]            rsp_slot_ff, rsp_slot_in;
   logic                     rsp_evict_ff, rsp_evict_in;
   lfupt_pkg::proc_type      rsp_vproc_ff, rsp_vproc_in;
   lfupt_pkg::page_type      rsp_vpage_ff, rsp_vpage_in;
   logic [CNTW-1:0]          rsp_match_ff, rsp_match_in;

   logic                     req_fire;
   logic                     wr_en;
   logic [IW-1:0]            wr_addr;
   logic [DW-1:0]            wr_data;
   logic [IW-1:0]            rd_addr;
   logic [DW-1:0]            rd_data;
   lfupt_pkg::proc_type      rd_proc;
   lfupt_pkg::page_type      rd_page;
   logic [COUNT_WIDTH-1:0]   rd_cnt;
   logic [CNTW-1:0]          scan_idx;
   logic                     entry_valid;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;

   assign rd_proc     = rd_data[DW-1 -: lfupt_pkg::PROC_W];
   assign rd_page     = rd_data[COUNT_WIDTH +: lfupt_pkg::PAGE_W];
   assign rd_cnt      = rd_data[COUNT_WIDTH-1:0];
   // entry whose read data is on rd_data this cycle
   assign scan_idx    = scan_ff - CNTW'(1);
   assign entry_valid = (scan_idx < fill_ff);
   assign rd_addr     = scan_ff[IW-1:0];

   lfupt_ram #(
      .WIDTH (DW),
      .DEPTH (ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      scan_in      = scan_ff;
      matches_in   = matches_ff;
      cmd_in       = cmd_ff;
      pid_in       = pid_ff;
      page_in      = page_ff;
      slot_in      = slot_ff;
      evict_in     = evict_ff;
      best_cnt_in  = best_cnt_ff;
      vproc_in     = vproc_ff;
      vpage_in     = vpage_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_evict_in = rsp_evict_ff;
      rsp_vproc_in = rsp_vproc_ff;
      rsp_vpage_in = rsp_vpage_ff;
      rsp_match_in = rsp_match_ff;
      wr_en        = 1'b0;
      wr_addr      = scan_idx[IW-1:0];
      wr_data      = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd_in     = req_cmd;
               pid_in     = req_proc_id;
               page_in    = req_page_num;
               matches_in = '0;
               evict_in   = 1'b0;
               slot_in    = '0;
               scan_in    = '0;
               if (req_cmd == lfupt_pkg::CMD_INSERT && fill_ff != FULL) begin
                  // free slot: write straight away
                  wr_en    = 1'b1;
                  wr_addr  = fill_ff[IW-1:0];
                  wr_data  = {req_proc_id, req_page_num, CNT_INIT};
                  slot_in  = fill_ff[IW-1:0];
                  fill_in  = fill_ff + CNTW'(1);
                  state_in = S_RESP;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            scan_in = scan_ff + CNTW'(1);
            if (scan_ff != '0) begin
               if (cmd_ff == lfupt_pkg::CMD_ACCESS) begin
                  if (entry_valid && rd_proc == pid_ff) begin
                     wr_en      = 1'b1;
                     wr_data    = {rd_proc, rd_page,
                                   (rd_cnt == CNT_MAX) ? rd_cnt : rd_cnt + COUNT_WIDTH'(1)};
                     matches_in = matches_ff + CNTW'(1);
                  end
               end else begin
                  // table is full here; strict compare keeps the lowest index on ties
                  if (scan_ff == CNTW'(1) || rd_cnt < best_cnt_ff) begin
                     slot_in     = scan_idx[IW-1:0];
                     best_cnt_in = rd_cnt;
                     vproc_in    = rd_proc;
                     vpage_in    = rd_page;
                  end
               end
            end
            if (scan_ff == FULL) begin
               state_in = (cmd_ff == lfupt_pkg::CMD_INSERT) ? S_WRITE : S_RESP;
            end
         end
         S_WRITE: begin
            wr_en    = 1'b1;
            wr_addr  = slot_ff;
            wr_data  = {pid_ff, page_ff, CNT_INIT};
            evict_in = 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_slot_in  = slot_ff;
               rsp_evict_in = evict_ff;
               rsp_vproc_in = evict_ff ? vproc_ff : '0;
               rsp_vpage_in = evict_ff ? vpage_ff : '0;
               rsp_match_in = matches_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff      <= scan_in;
      matches_ff   <= matches_in;
      cmd_ff       <= cmd_in;
      pid_ff       <= pid_in;
      page_ff      <= page_in;
      slot_ff      <= slot_in;
      evict_ff     <= evict_in;
      best_cnt_ff  <= best_cnt_in;
      vproc_ff     <= vproc_in;
      vpage_ff     <= vpage_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_evict_ff <= rsp_evict_in;
      rsp_vproc_ff <= rsp_vproc_in;
      rsp_vpage_ff <= rsp_vpage_in;
      rsp_match_ff <= rsp_match_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_slot        = lfupt_pkg::SLOT_W'(rsp_slot_ff);
   assign rsp_evicted     = rsp_evict_ff;
   assign rsp_victim_proc = rsp_vproc_ff;
   assign rsp_victim_page = rsp_vpage_ff;
   assign rsp_match_count = lfupt_pkg::MATCH_W'(rsp_match_ff);

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FULL)
      else $error("fill count beyond table size");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> scan_ff <= FULL)
      else $error("scan ran past last entry");

   a_idle_write: assert property (@(posedge clock) disable iff (reset)
      wr_en && state_ff == S_IDLE |-> req_fire && req_cmd == lfupt_pkg::CMD_INSERT)
      else $error("table written while idle without an insert");

   a_evict_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_evict_ff |-> fill_ff == FULL)
      else $error("eviction reported with free slots left");

   a_write_after_scan: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WRITE |-> $past(state_ff) == S_SCAN && cmd_ff == lfupt_pkg::CMD_INSERT)
      else $error("replacement write without a completed insert scan");

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;

   localparam int ENTRIES = 8;
   localparam int COUNT_W = 16;

   typedef struct packed {
      logic [lfupt_pkg::SLOT_W-1:0]  slot;
      logic                          evicted;
      lfupt_pkg::proc_type           victim_proc;
      lfupt_pkg::page_type           victim_page;
      logic [lfupt_pkg::MATCH_W-1:0] match_count;
   } table_reply_type;

   typedef struct {
      logic                cmd;
      lfupt_pkg::proc_type pid;
      lfupt_pkg::page_type page;
      bit                  typed;
      table_reply_type     reply;
   } stim_row_type;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   logic                          req_cmd;
   lfupt_pkg::proc_type           req_proc_id;
   lfupt_pkg::page_type           req_page_num;
   logic                          rsp_valid;
   logic                          rsp_ready;
   logic [lfupt_pkg::SLOT_W-1:0]  rsp_slot;
   logic                          rsp_evicted;
   lfupt_pkg::proc_type           rsp_victim_proc;
   lfupt_pkg::page_type           rsp_victim_page;
   logic [lfupt_pkg::MATCH_W-1:0] rsp_match_count;

   // shadow copy of the table
   bit [ENTRIES-1:0]              tbl_valid;
   lfupt_pkg::proc_type           tbl_proc [ENTRIES];
   lfupt_pkg::page_type           tbl_page [ENTRIES];
   bit [COUNT_W-1:0]              tbl_count [ENTRIES];
   int                            tbl_fill;

   table_reply_type               pending_replies[$];
   stim_row_type                  directed_rows[$];
   int                            err_count;
   bit                            no_idle;

   lfu_page_table_unit #(
      .ENTRIES     (ENTRIES),
      .COUNT_WIDTH (COUNT_W)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_proc_id     (req_proc_id),
      .req_page_num    (req_page_num),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_slot        (rsp_slot),
      .rsp_evicted     (rsp_evicted),
      .rsp_victim_proc (rsp_victim_proc),
      .rsp_victim_page (rsp_victim_page),
      .rsp_match_count (rsp_match_count)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      #(50_000_000);
      $display("tb: errors");
      $finish;
   end

   task automatic report(input string msg);
      $display("%0t: %s", $realtime, msg);
      err_count++;
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // insert fills in order, then replaces the lowest count (lowest index on ties);
   // access bumps every valid entry with that process id, saturating
   function automatic table_reply_type apply_table_op(input logic cmd,
                                                      input lfupt_pkg::proc_type pid,
                                                      input lfupt_pkg::page_type page);
      table_reply_type r;
      int              best;
      int              matched;
      bit              found;
      r = '0;
      best = 0;
      matched = 0;
      found = 1'b0;
      if (cmd == lfupt_pkg::CMD_INSERT) begin
         if (tbl_fill < ENTRIES) begin
            best = tbl_fill;
            tbl_fill++;
         end else begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (tbl_valid[i] && (!found || tbl_count[i] < tbl_count[best])) begin
                  best = i;
                  found = 1'b1;
               end
            end
            if (found) begin
               r.evicted = 1'b1;
               r.victim_proc = tbl_proc[best];
               r.victim_page = tbl_page[best];
            end
         end
         r.slot = lfupt_pkg::SLOT_W'(best);
         tbl_valid[best] = 1'b1;
         tbl_proc[best] = pid;
         tbl_page[best] = page;
         tbl_count[best] = COUNT_W'(lfupt_pkg::INIT_COUNT);
      end else begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (tbl_valid[i] && tbl_proc[i] == pid) begin
               if (tbl_count[i] != '1) tbl_count[i]++;
               matched++;
            end
         end
         r.match_count = lfupt_pkg::MATCH_W'(matched);
      end
      return r;
   endfunction

   task automatic send_request(input logic cmd, input lfupt_pkg::proc_type pid,
                               input lfupt_pkg::page_type page,
                               input bit typed, input table_reply_type typed_reply);
      table_reply_type predicted;
      @(negedge clock);
      req_valid = 1'b1;
      req_cmd = cmd;
      req_proc_id = pid;
      req_page_num = page;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = apply_table_op(cmd, pid, page);
      pending_replies.push_back(typed ? typed_reply : predicted);
   endtask

   task automatic idle_for(input int gap);
      if (gap > 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic add_row(input logic cmd, input lfupt_pkg::proc_type pid,
                          input lfupt_pkg::page_type page,
                          input bit typed, input int slot, input bit ev,
                          input lfupt_pkg::proc_type vproc,
                          input lfupt_pkg::page_type vpage, input int mc);
      stim_row_type row;
      row.cmd = cmd;
      row.pid = pid;
      row.page = page;
      row.typed = typed;
      row.reply.slot = lfupt_pkg::SLOT_W'(slot);
      row.reply.evicted = ev;
      row.reply.victim_proc = vproc;
      row.reply.victim_page = vpage;
      row.reply.match_count = lfupt_pkg::MATCH_W'(mc);
      directed_rows.push_back(row);
   endtask

   // result checker
   always @(posedge clock) begin
      table_reply_type got;
      table_reply_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got.slot = rsp_slot;
         got.evicted = rsp_evicted;
         got.victim_proc = rsp_victim_proc;
         got.victim_page = rsp_victim_page;
         got.match_count = rsp_match_count;
         if (pending_replies.size() == 0) begin
            report($sformatf("result with nothing outstanding: %h", got));
         end else begin
            want = pending_replies.pop_front();
            if (got.slot !== want.slot)
               report($sformatf("slot got %0d want %0d", got.slot, want.slot));
            if (got.evicted !== want.evicted)
               report($sformatf("evicted got %0b want %0b", got.evicted, want.evicted));
            if (got.victim_proc !== want.victim_proc)
               report($sformatf("victim_proc got %h want %h",
                                got.victim_proc, want.victim_proc));
            if (got.victim_page !== want.victim_page)
               report($sformatf("victim_page got %h want %h",
                                got.victim_page, want.victim_page));
            if (got.match_count !== want.match_count)
               report($sformatf("match_count got %0d want %0d",
                                got.match_count, want.match_count));
         end
      end
   end

   // result side back-pressure
   initial begin
      rsp_ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         rsp_ready = 1'b1;
         repeat ($urandom_range(1, 12)) @(negedge clock);
         if (!no_idle) begin
            rsp_ready = 1'b0;
            repeat (pick_gap()) @(negedge clock);
         end
      end
   end

   initial begin
      lfupt_pkg::proc_type pid_pool [6];
      lfupt_pkg::proc_type pid;
      lfupt_pkg::page_type page;
      logic                cmd;
      int                  r;
      table_reply_type     none;

      reset = 1'b1;
      req_valid = 1'b0;
      req_cmd = lfupt_pkg::CMD_INSERT;
      req_proc_id = '0;
      req_page_num = '0;
      err_count = 0;
      no_idle = 1'b0;
      tbl_valid = '0;
      tbl_fill = 0;
      none = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         tbl_proc[i] = '0;
         tbl_page[i] = '0;
         tbl_count[i] = '0;
      end

      // empty table, fill in order, then eviction by lowest count and index
      add_row(lfupt_pkg::CMD_ACCESS, 8'hFF, 20'hFFFFF, 1, 0, 0, 8'h00, 20'h00000, 0);
      add_row(lfupt_pkg::CMD_INSERT, 8'h00, 20'h00000, 1, 0, 0, 8'h00, 20'h00000, 0);
      add_row(lfupt_pkg::CMD_INSERT, 8'hFF, 20'hFFFFF, 1, 1, 0, 8'h00, 20'h00000, 0);
      add_row(lfupt_pkg::CMD_INSERT, 8'h55, 20'h55555, 1, 2, 0, 8'h00, 20'h00000, 0);
      add_row(lfupt_pkg::CMD_INSERT, 8'hAA, 20'hAAAAA, 1, 3, 0, 8'h00, 20'h00000, 0);
      add_row(lfupt_pkg::CMD_INSERT, 8'h00, 20'h0F0F0, 1, 4, 0, 8'h00, 20'h00000, 0);
      add_row(lfupt_pkg::CMD_INSERT, 8'h00, 20'hF0F0F, 1, 5, 0, 8'h00, 20'h00000, 0);
      add_row(lfupt_pkg::CMD_INSERT, 8'h00, 20'h00001, 1, 6, 0, 8'h00, 20'h00000, 0);
      add_row(lfupt_pkg::CMD_INSERT, 8'h00, 20'h80000, 1, 7, 0, 8'h00, 20'h00000, 0);
      add_row(lfupt_pkg::CMD_ACCESS, 8'h00, 20'h00000, 1, 0, 0, 8'h00, 20'h00000, 5);
      add_row(lfupt_pkg::CMD_ACCESS, 8'h01, 20'h00000, 1, 0, 0, 8'h00, 20'h00000, 0);
      add_row(lfupt_pkg::CMD_INSERT, 8'h12, 20'h12345, 1, 1, 1, 8'hFF, 20'hFFFFF, 0);
      add_row(lfupt_pkg::CMD_INSERT, 8'h34, 20'h6789A, 0, 0, 0, 8'h00, 20'h00000, 0);
      add_row(lfupt_pkg::CMD_ACCESS, 8'h00, 20'hFFFFF, 0, 0, 0, 8'h00, 20'h00000, 0);
      add_row(lfupt_pkg::CMD_ACCESS, 8'h55, 20'h00000, 0, 0, 0, 8'h00, 20'h00000, 0);
      add_row(lfupt_pkg::CMD_INSERT, 8'h00, 20'h00000, 0, 0, 0, 8'h00, 20'h00000, 0);
      add_row(lfupt_pkg::CMD_ACCESS, 8'h00, 20'h00000, 0, 0, 0, 8'h00, 20'h00000, 0);
      add_row(lfupt_pkg::CMD_INSERT, 8'h00, 20'hFFFFF, 0, 0, 0, 8'h00, 20'h00000, 0);
      add_row(lfupt_pkg::CMD_ACCESS, 8'h00, 20'h00000, 0, 0, 0, 8'h00, 20'h00000, 0);
      add_row(lfupt_pkg::CMD_INSERT, 8'h00, 20'h11111, 0, 0, 0, 8'h00, 20'h00000, 0);
      add_row(lfupt_pkg::CMD_ACCESS, 8'h00, 20'h00000, 1, 0, 0, 8'h00, 20'h00000, 8);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].cmd, directed_rows[i].pid, directed_rows[i].page,
                      directed_rows[i].typed, directed_rows[i].reply);
         idle_for(pick_gap());
      end

      foreach (pid_pool[i]) pid_pool[i] = lfupt_pkg::proc_type'($urandom);
      for (int n = 0; n < 1250; n++) begin
         no_idle = (n >= 400 && n < 550);
         if (n == 700) begin
            // let all outstanding results come back before carrying on
            idle_for(1);
            while (pending_replies.size() != 0) @(posedge clock);
         end
         cmd = ($urandom_range(0, 1) == 0) ? lfupt_pkg::CMD_INSERT : lfupt_pkg::CMD_ACCESS;
         r = $urandom_range(0, 99);
         pid = (r < 70) ? pid_pool[$urandom_range(0, 5)] : lfupt_pkg::proc_type'($urandom);
         r = $urandom_range(0, 99);
         page = (r < 10) ? '1 : (r < 20) ? '0 : lfupt_pkg::page_type'($urandom);
         send_request(cmd, pid, page, 0, none);
         idle_for(pick_gap());
      end
      no_idle = 1'b0;

      idle_for(1);
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (2 * ENTRIES + 8) @(posedge clock);
      if (pending_replies.size() != 0)
         report($sformatf("%0d results never arrived", pending_replies.size()));
      if (err_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
